>>> rtl/core/spa_pkg.sv
// Shared constants, register map, operation codes and control types of the sparse polynomial ALU.
`default_nettype none
package spa_pkg;

  localparam int MaxTerms  = 8;
  localparam int WorkDepth = 64;

  localparam int TermIdxW  = $clog2(MaxTerms);
  localparam int TermCntW  = $clog2(MaxTerms + 1);
  localparam int WorkAddrW = $clog2(WorkDepth);
  localparam int WorkCntW  = $clog2(WorkDepth + 1);

  localparam int CoefW   = 32;
  localparam int ExpW    = 10;
  localparam int OutExpW = 11;
  localparam int OpW     = 3;
  localparam int PaddrW  = 5;
  localparam int RegIdxW = 3;

  localparam logic [OpW-1:0] OpAdd   = 3'd0;
  localparam logic [OpW-1:0] OpSub   = 3'd1;
  localparam logic [OpW-1:0] OpScale = 3'd2;
  localparam logic [OpW-1:0] OpProd  = 3'd3;
  localparam logic [OpW-1:0] OpMono  = 3'd4;
  localparam logic [OpW-1:0] OpEval  = 3'd5;

  localparam logic [RegIdxW-1:0] RegOperation = 3'd0;
  localparam logic [RegIdxW-1:0] RegScale     = 3'd1;
  localparam logic [RegIdxW-1:0] RegPoint     = 3'd2;
  localparam logic [RegIdxW-1:0] RegMonoCoef  = 3'd3;
  localparam logic [RegIdxW-1:0] RegMonoExp   = 3'd4;

  localparam logic [CoefW-1:0] CoefOne      = 32'd1;
  localparam logic [CoefW-1:0] CoefMinusOne = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [CoefW-1:0] scale;
    logic [CoefW-1:0] point;
    logic [CoefW-1:0] mono_coef;
    logic [ExpW-1:0]  mono_exp;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic gen_init;
    logic gen_mul;
    logic gen_wr;
    logic m_init;
    logic m_skip_i;
    logic m_rd_i;
    logic m_ld_i;
    logic m_skip_j;
    logic m_rd_j;
    logic m_cmp;
    logic m_wb;
    logic e_init;
    logic e_skip;
    logic e_rd;
    logic e_out_term;
    logic e_out_empty;
    logic e_out_eval;
    logic ev_term_init;
    logic ev_mul_r;
    logic ev_sq;
    logic ev_cmul;
    logic ev_acc;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic is_eval;
    logic has_term;
    logic mi_done;
    logic mi_valid;
    logic mj_done;
    logic mj_valid;
    logic any;
    logic ek_last;
    logic ev_done;
    logic e_zero;
    logic e_odd;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/spa_if.sv
// Handshake interfaces for the term input channel and the result output channel.
`default_nettype none
interface spa_term_if;
  logic        valid;
  logic        ready;
  logic        operand_select;
  logic [31:0] term_coefficient;
  logic [9:0]  term_exponent;
  logic        last_term;

  modport source (output valid, operand_select, term_coefficient, term_exponent, last_term,
                  input ready);
  modport sink (input valid, operand_select, term_coefficient, term_exponent, last_term,
                output ready);
endinterface

interface spa_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_coefficient;
  logic [10:0] out_exponent;
  logic [31:0] eval_value;
  logic        empty_result;
  logic        terms_dropped;
  logic        last_result;

  modport source (output valid, out_coefficient, out_exponent, eval_value, empty_result,
                  terms_dropped, last_result, input ready);
  modport sink (input valid, out_coefficient, out_exponent, eval_value, empty_result,
                terms_dropped, last_result, output ready);
endinterface
`default_nettype wire

>>> rtl/core/spa_dp.sv
// Datapath: operand stores, work memory, shared multiplier, merge and output register.
`default_nettype none
module spa_dp import spa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  spa_term_if.sink         term_in,
  spa_result_if.source     result_out
);

  logic [CoefW-1:0]    c1_q [MaxTerms];
  logic [ExpW-1:0]     e1_q [MaxTerms];
  logic [CoefW-1:0]    c2_q [MaxTerms];
  logic [ExpW-1:0]     e2_q [MaxTerms];
  logic [TermCntW-1:0] cnt1_q, cnt2_q;
  logic                ovf_q;

  logic [TermCntW-1:0] gi_q, gj_q;
  logic                ph_q;
  logic [WorkCntW-1:0] wcnt_q;
  logic [CoefW-1:0]    prod_q;
  logic [OutExpW-1:0]  pexp_q;

  logic [CoefW-1:0]    wc_mem [WorkDepth];
  logic [OutExpW-1:0]  we_mem [WorkDepth];
  logic                wv_q [WorkDepth];
  logic [CoefW-1:0]    rdc_q;
  logic [OutExpW-1:0]  rde_q;

  logic [WorkCntW-1:0]  mi_q, mj_q;
  logic [CoefW-1:0]     macc_q;
  logic [OutExpW-1:0]   mexp_q;
  logic [WorkAddrW-1:0] last_q;
  logic                 any_q;

  logic [CoefW-1:0] r_q, base_q, acc_q;
  logic [ExpW-1:0]  pe_q;

  logic               ov_q;
  logic [CoefW-1:0]   oc_q, oval_q;
  logic [OutExpW-1:0] oe_q;
  logic               oempty_q, odrop_q, olast_q;

  logic [OpW-1:0]       op;
  logic                 is_prod, is_addsub, final_sel, in_fire;
  logic [TermIdxW-1:0]  ia, ja;
  logic [CoefW-1:0]     mul_a, mul_b, mul_y;
  logic [OutExpW-1:0]   gen_exp;
  logic                 wr_en;
  logic [WorkAddrW-1:0] wr_addr, rd_addr;
  logic [CoefW-1:0]     wr_coef;
  logic [OutExpW-1:0]   wr_exp;
  logic                 rd_en;
  logic                 out_free;

  // Unused codes behave as add.
  assign op        = (cfg_i.op > OpEval) ? OpAdd : cfg_i.op;
  assign is_prod   = (op == OpProd);
  assign is_addsub = (op == OpAdd) || (op == OpSub);
  // Single-operand modes start on the first operand, the rest on the second.
  assign final_sel = !((op == OpScale) || (op == OpMono) || (op == OpEval));
  assign in_fire   = term_in.valid && cmd_i.load;
  assign term_in.ready = cmd_i.load;

  assign ia = gi_q[TermIdxW-1:0];
  assign ja = gj_q[TermIdxW-1:0];

  always_comb begin
    mul_a = c1_q[ia];
    mul_b = CoefOne;
    if (cmd_i.ev_mul_r) begin
      mul_a = r_q;
      mul_b = base_q;
    end else if (cmd_i.ev_sq) begin
      mul_a = base_q;
      mul_b = base_q;
    end else if (cmd_i.ev_cmul) begin
      mul_a = c1_q[ia];
      mul_b = r_q;
    end else if (is_prod) begin
      mul_b = c2_q[ja];
    end else if (ph_q) begin
      mul_a = c2_q[ja];
      mul_b = (op == OpSub) ? CoefMinusOne : CoefOne;
    end else if (op == OpScale) begin
      mul_b = cfg_i.scale;
    end else if (op == OpMono) begin
      mul_b = cfg_i.mono_coef;
    end
  end

  assign mul_y = mul_a * mul_b;

  always_comb begin
    if (is_prod) begin
      gen_exp = {1'b0, e1_q[ia]} + {1'b0, e2_q[ja]};
    end else if (ph_q) begin
      gen_exp = {1'b0, e2_q[ja]};
    end else if (op == OpMono) begin
      gen_exp = {1'b0, e1_q[ia]} + {1'b0, cfg_i.mono_exp};
    end else begin
      gen_exp = {1'b0, e1_q[ia]};
    end
  end

  // Operand stores.
  always_ff @(posedge clk_i) begin
    if (in_fire && !term_in.operand_select && (cnt1_q < TermCntW'(MaxTerms))) begin
      c1_q[cnt1_q[TermIdxW-1:0]] <= term_in.term_coefficient;
      e1_q[cnt1_q[TermIdxW-1:0]] <= term_in.term_exponent;
    end
    if (in_fire && term_in.operand_select && (cnt2_q < TermCntW'(MaxTerms))) begin
      c2_q[cnt2_q[TermIdxW-1:0]] <= term_in.term_coefficient;
      e2_q[cnt2_q[TermIdxW-1:0]] <= term_in.term_exponent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt1_q <= '0;
      cnt2_q <= '0;
      ovf_q  <= 1'b0;
    end else if (cmd_i.finish) begin
      cnt1_q <= '0;
      cnt2_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        if (!term_in.operand_select) begin
          if (cnt1_q < TermCntW'(MaxTerms)) cnt1_q <= cnt1_q + 1'b1;
          else ovf_q <= 1'b1;
        end else begin
          if (cnt2_q < TermCntW'(MaxTerms)) cnt2_q <= cnt2_q + 1'b1;
          else ovf_q <= 1'b1;
        end
      end
      if (cmd_i.gen_wr && (wcnt_q >= WorkCntW'(WorkDepth))) ovf_q <= 1'b1;
    end
  end

  // Term generation and evaluation sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gi_q   <= '0;
      gj_q   <= '0;
      ph_q   <= 1'b0;
      wcnt_q <= '0;
    end else if (cmd_i.gen_init) begin
      gi_q   <= '0;
      gj_q   <= '0;
      ph_q   <= is_addsub && (cnt1_q == '0);
      wcnt_q <= '0;
    end else if (cmd_i.gen_wr) begin
      if (wcnt_q < WorkCntW'(WorkDepth)) wcnt_q <= wcnt_q + 1'b1;
      if (is_prod) begin
        if (TermCntW'(gj_q + 1'b1) == cnt2_q) begin
          gj_q <= '0;
          gi_q <= gi_q + 1'b1;
        end else begin
          gj_q <= gj_q + 1'b1;
        end
      end else if (ph_q) begin
        gj_q <= gj_q + 1'b1;
      end else begin
        gi_q <= gi_q + 1'b1;
        if (is_addsub && (TermCntW'(gi_q + 1'b1) == cnt1_q)) ph_q <= 1'b1;
      end
    end else if (cmd_i.ev_acc) begin
      gi_q <= gi_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gen_mul || cmd_i.ev_cmul) prod_q <= mul_y;
    if (cmd_i.gen_mul) pexp_q <= gen_exp;
    if (cmd_i.gen_init) acc_q <= '0;
    else if (cmd_i.ev_acc) acc_q <= acc_q + prod_q;
    if (cmd_i.ev_term_init) begin
      r_q    <= CoefOne;
      base_q <= cfg_i.point;
      pe_q   <= e1_q[ia];
    end else begin
      if (cmd_i.ev_mul_r) r_q <= mul_y;
      if (cmd_i.ev_sq) begin
        base_q <= mul_y;
        pe_q   <= pe_q >> 1;
      end
    end
  end

  // Work memory: one write port, one registered read port.
  assign wr_en   = (cmd_i.gen_wr && (wcnt_q < WorkCntW'(WorkDepth))) || cmd_i.m_wb;
  assign wr_addr = cmd_i.m_wb ? mi_q[WorkAddrW-1:0] : wcnt_q[WorkAddrW-1:0];
  assign wr_coef = cmd_i.m_wb ? macc_q : prod_q;
  assign wr_exp  = cmd_i.m_wb ? mexp_q : pexp_q;
  assign rd_en   = cmd_i.m_rd_i || cmd_i.m_rd_j || cmd_i.e_rd;
  assign rd_addr = cmd_i.m_rd_j ? mj_q[WorkAddrW-1:0] : mi_q[WorkAddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wc_mem[wr_addr] <= wr_coef;
      we_mem[wr_addr] <= wr_exp;
    end
    if (rd_en) begin
      rdc_q <= wc_mem[rd_addr];
      rde_q <= we_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gen_wr && (wcnt_q < WorkCntW'(WorkDepth))) wv_q[wcnt_q[WorkAddrW-1:0]] <= 1'b1;
    if (cmd_i.m_cmp && (rde_q == mexp_q)) wv_q[mj_q[WorkAddrW-1:0]] <= 1'b0;
    if (cmd_i.m_wb) wv_q[mi_q[WorkAddrW-1:0]] <= (macc_q != '0);
  end

  // Merge of like exponents; the emit pass reuses the outer index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mi_q   <= '0;
      mj_q   <= '0;
      any_q  <= 1'b0;
      last_q <= '0;
    end else begin
      if (cmd_i.m_init) begin
        mi_q  <= '0;
        any_q <= 1'b0;
      end
      if (cmd_i.e_init) mi_q <= '0;
      if (cmd_i.m_skip_i || cmd_i.e_skip || cmd_i.e_out_term) mi_q <= mi_q + 1'b1;
      if (cmd_i.m_ld_i) mj_q <= mi_q + 1'b1;
      if (cmd_i.m_skip_j || cmd_i.m_cmp) mj_q <= mj_q + 1'b1;
      if (cmd_i.m_wb) begin
        mi_q <= mi_q + 1'b1;
        if (macc_q != '0) begin
          any_q  <= 1'b1;
          last_q <= mi_q[WorkAddrW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.m_ld_i) begin
      macc_q <= rdc_q;
      mexp_q <= rde_q;
    end else if (cmd_i.m_cmp && (rde_q == mexp_q)) begin
      macc_q <= macc_q + rdc_q;
    end
  end

  // Output register.
  assign out_free = !ov_q || result_out.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.e_out_term || cmd_i.e_out_empty || cmd_i.e_out_eval) begin
      ov_q <= 1'b1;
    end else if (result_out.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.e_out_term || cmd_i.e_out_empty || cmd_i.e_out_eval) begin
      oc_q     <= cmd_i.e_out_term ? rdc_q : '0;
      oe_q     <= cmd_i.e_out_term ? rde_q : '0;
      oval_q   <= cmd_i.e_out_eval ? acc_q : '0;
      oempty_q <= cmd_i.e_out_empty;
      odrop_q  <= ovf_q;
      olast_q  <= cmd_i.e_out_term ? (mi_q[WorkAddrW-1:0] == last_q) : 1'b1;
    end
  end

  assign result_out.valid           = ov_q;
  assign result_out.out_coefficient = oc_q;
  assign result_out.out_exponent    = oe_q;
  assign result_out.eval_value      = oval_q;
  assign result_out.empty_result    = oempty_q;
  assign result_out.terms_dropped   = odrop_q;
  assign result_out.last_result     = olast_q;

  always_comb begin
    sts_o.start    = term_in.last_term && (term_in.operand_select == final_sel);
    sts_o.is_eval  = (op == OpEval);
    sts_o.has_term = is_prod ? ((gi_q < cnt1_q) && (cnt2_q != '0))
                             : (ph_q ? (gj_q < cnt2_q) : (gi_q < cnt1_q));
    sts_o.mi_done  = (mi_q >= wcnt_q);
    sts_o.mi_valid = wv_q[mi_q[WorkAddrW-1:0]];
    sts_o.mj_done  = (mj_q >= wcnt_q);
    sts_o.mj_valid = wv_q[mj_q[WorkAddrW-1:0]];
    sts_o.any      = any_q;
    sts_o.ek_last  = (mi_q[WorkAddrW-1:0] == last_q);
    sts_o.ev_done  = (gi_q >= cnt1_q);
    sts_o.e_zero   = (pe_q == '0);
    sts_o.e_odd    = pe_q[0];
    sts_o.out_free = out_free;
  end

endmodule
`default_nettype wire

>>> rtl/core/spa_ctrl.sv
// Controller state machine: sequences load, term generation, merge, emit and evaluation.
`default_nettype none
module spa_ctrl import spa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [4:0] SLoad    = 5'd0;
  localparam logic [4:0] SInit    = 5'd1;
  localparam logic [4:0] SGenMul  = 5'd2;
  localparam logic [4:0] SGenWr   = 5'd3;
  localparam logic [4:0] SMRdI    = 5'd4;
  localparam logic [4:0] SMLdI    = 5'd5;
  localparam logic [4:0] SMRdJ    = 5'd6;
  localparam logic [4:0] SMCmp    = 5'd7;
  localparam logic [4:0] SMWb     = 5'd8;
  localparam logic [4:0] SERd     = 5'd9;
  localparam logic [4:0] SEOut    = 5'd10;
  localparam logic [4:0] SEEmpty  = 5'd11;
  localparam logic [4:0] SEvTerm  = 5'd12;
  localparam logic [4:0] SEvStep  = 5'd13;
  localparam logic [4:0] SEvSq    = 5'd14;
  localparam logic [4:0] SEvAcc   = 5'd15;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SLoad;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SLoad: begin
        cmd_o.load = 1'b1;
        if (in_valid_i && sts_i.start) state_d = SInit;
      end
      SInit: begin
        cmd_o.gen_init = 1'b1;
        state_d = sts_i.is_eval ? SEvTerm : SGenMul;
      end
      SGenMul: begin
        if (!sts_i.has_term) begin
          cmd_o.m_init = 1'b1;
          state_d = SMRdI;
        end else begin
          cmd_o.gen_mul = 1'b1;
          state_d = SGenWr;
        end
      end
      SGenWr: begin
        cmd_o.gen_wr = 1'b1;
        state_d = SGenMul;
      end
      SMRdI: begin
        if (sts_i.mi_done) begin
          cmd_o.e_init = 1'b1;
          state_d = sts_i.any ? SERd : SEEmpty;
        end else if (!sts_i.mi_valid) begin
          cmd_o.m_skip_i = 1'b1;
        end else begin
          cmd_o.m_rd_i = 1'b1;
          state_d = SMLdI;
        end
      end
      SMLdI: begin
        cmd_o.m_ld_i = 1'b1;
        state_d = SMRdJ;
      end
      SMRdJ: begin
        if (sts_i.mj_done) begin
          state_d = SMWb;
        end else if (sts_i.mj_valid) begin
          cmd_o.m_rd_j = 1'b1;
          state_d = SMCmp;
        end else begin
          cmd_o.m_skip_j = 1'b1;
        end
      end
      SMCmp: begin
        cmd_o.m_cmp = 1'b1;
        state_d = SMRdJ;
      end
      SMWb: begin
        cmd_o.m_wb = 1'b1;
        state_d = SMRdI;
      end
      SERd: begin
        if (!sts_i.mi_valid) begin
          cmd_o.e_skip = 1'b1;
        end else begin
          cmd_o.e_rd = 1'b1;
          state_d = SEOut;
        end
      end
      SEOut: begin
        if (sts_i.out_free) begin
          cmd_o.e_out_term = 1'b1;
          if (sts_i.ek_last) begin
            cmd_o.finish = 1'b1;
            state_d = SLoad;
          end else begin
            state_d = SERd;
          end
        end
      end
      SEEmpty: begin
        if (sts_i.out_free) begin
          cmd_o.e_out_empty = 1'b1;
          cmd_o.finish = 1'b1;
          state_d = SLoad;
        end
      end
      SEvTerm: begin
        if (sts_i.ev_done) begin
          if (sts_i.out_free) begin
            cmd_o.e_out_eval = 1'b1;
            cmd_o.finish = 1'b1;
            state_d = SLoad;
          end
        end else begin
          cmd_o.ev_term_init = 1'b1;
          state_d = SEvStep;
        end
      end
      SEvStep: begin
        if (sts_i.e_zero) begin
          cmd_o.ev_cmul = 1'b1;
          state_d = SEvAcc;
        end else if (sts_i.e_odd) begin
          cmd_o.ev_mul_r = 1'b1;
          state_d = SEvSq;
        end else begin
          cmd_o.ev_sq = 1'b1;
        end
      end
      SEvSq: begin
        cmd_o.ev_sq = 1'b1;
        state_d = SEvStep;
      end
      SEvAcc: begin
        cmd_o.ev_acc = 1'b1;
        state_d = SEvTerm;
      end
      default: begin
        state_d = SLoad;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/sparse_polynomial_alu.sv
// Top level of the sparse polynomial ALU: configuration registers, controller and datapath.
`default_nettype none
// Terms are taken one per cycle while the block waits for operands. The beat that carries
// the final operand's last term starts a run, and no term is taken until the run's last
// result is in the output register. A run builds up to 64 work terms, each in a multiply
// state and a write state, through the shared 32x32 multiplier, then merges like exponents
// over the work memory, reading each live entry against every later one, then emits the
// result beats, each with a read state and an output state. Evaluation works each loaded
// term by square-and-multiply in the same multiplier. The output register holds a result
// beat while the next terms load.
module sparse_polynomial_alu import spa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  spa_term_if.sink          term_in,
  spa_result_if.source      result_out
);

  cfg_t               cfg_q;
  cmd_t               cmd;
  sts_t               sts;
  logic               cfg_we;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrW-1:2];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.op        <= OpAdd;
      cfg_q.scale     <= CoefOne;
      cfg_q.point     <= '0;
      cfg_q.mono_coef <= CoefOne;
      cfg_q.mono_exp  <= '0;
    end else if (cfg_we) begin
      case (reg_idx)
        RegOperation: cfg_q.op        <= pwdata[OpW-1:0];
        RegScale:     cfg_q.scale     <= pwdata;
        RegPoint:     cfg_q.point     <= pwdata;
        RegMonoCoef:  cfg_q.mono_coef <= pwdata;
        RegMonoExp:   cfg_q.mono_exp  <= pwdata[ExpW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegOperation: prdata = {{(32-OpW){1'b0}}, cfg_q.op};
      RegScale:     prdata = cfg_q.scale;
      RegPoint:     prdata = cfg_q.point;
      RegMonoCoef:  prdata = cfg_q.mono_coef;
      RegMonoExp:   prdata = {{(32-ExpW){1'b0}}, cfg_q.mono_exp};
      default:      prdata = '0;
    endcase
  end

  spa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (term_in.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spa_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .term_in    (term_in),
    .result_out (result_out)
  );

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the sparse polynomial ALU: directed and random term streams.
`timescale 1ns / 1ps
module tb;
  import spa_pkg::*;

  localparam logic [OpW-1:0] OpSpare6 = 3'd6;
  localparam logic [OpW-1:0] OpSpare7 = 3'd7;
  localparam int IdleLimit  = 20000;
  localparam int SettleCyc  = 40;

  typedef struct packed {
    logic [CoefW-1:0]   coef;
    logic [OutExpW-1:0] expo;
    logic [CoefW-1:0]   value;
    logic               empty;
    logic               dropped;
    logic               last;
  } poly_beat_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  spa_term_if   term_if ();
  spa_result_if res_if ();

  sparse_polynomial_alu i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .term_in    (term_if.sink),
    .result_out (res_if.source)
  );

  // Shadow of the block's registers and term stores
  cfg_t             shadow_cfg;
  logic [CoefW-1:0] first_coef [MaxTerms];
  logic [ExpW-1:0]  first_exp  [MaxTerms];
  logic [CoefW-1:0] second_coef[MaxTerms];
  logic [ExpW-1:0]  second_exp [MaxTerms];
  int               first_n, second_n;
  logic             spill_seen;

  poly_beat_t result_q[$];
  int  err_count;
  int  tx_idle_pct, rx_idle_pct;
  int  rx_hold_cycles;
  int  quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic logic [CoefW-1:0] ipow(input logic [CoefW-1:0] base,
                                            input logic [ExpW-1:0] e);
    logic [CoefW-1:0] r;
    r = CoefOne;
    for (int b = 0; b < ExpW; b++) begin
      if (e[b]) r = r * base;
      base = base * base;
    end
    return r;
  endfunction

  // Compute the expected beats of one run and queue them
  task automatic run_poly();
    logic [CoefW-1:0]   wc[WorkDepth];
    logic [OutExpW-1:0] we[WorkDepth];
    bit                 live[WorkDepth];
    logic [OpW-1:0]     op;
    logic [CoefW-1:0]   acc;
    poly_beat_t         b;
    int                 wn, last_idx;
    op = (shadow_cfg.op > OpEval) ? OpAdd : shadow_cfg.op;
    wn = 0;
    if (op == OpEval) begin
      acc = '0;
      for (int i = 0; i < first_n; i++)
        acc += first_coef[i] * ipow(shadow_cfg.point, first_exp[i]);
      b = '{coef: '0, expo: '0, value: acc, empty: 1'b0, dropped: spill_seen, last: 1'b1};
      result_q.push_back(b);
      return;
    end
    if (op == OpScale || op == OpMono) begin
      for (int i = 0; i < first_n; i++) begin
        if (op == OpScale) begin
          wc[wn] = first_coef[i] * shadow_cfg.scale;
          we[wn] = OutExpW'(first_exp[i]);
        end else begin
          wc[wn] = first_coef[i] * shadow_cfg.mono_coef;
          we[wn] = OutExpW'(first_exp[i]) + OutExpW'(shadow_cfg.mono_exp);
        end
        wn++;
      end
    end else if (op == OpProd) begin
      for (int i = 0; i < first_n; i++)
        for (int j = 0; j < second_n; j++) begin
          wc[wn] = first_coef[i] * second_coef[j];
          we[wn] = OutExpW'(first_exp[i]) + OutExpW'(second_exp[j]);
          wn++;
        end
    end else begin
      for (int i = 0; i < first_n; i++) begin
        wc[wn] = first_coef[i];
        we[wn] = OutExpW'(first_exp[i]);
        wn++;
      end
      for (int j = 0; j < second_n; j++) begin
        wc[wn] = (op == OpSub) ? -second_coef[j] : second_coef[j];
        we[wn] = OutExpW'(second_exp[j]);
        wn++;
      end
    end
    for (int i = 0; i < wn; i++) live[i] = 1'b1;
    for (int i = 0; i < wn; i++) begin
      if (!live[i]) continue;
      for (int j = i + 1; j < wn; j++)
        if (live[j] && we[j] == we[i]) begin
          wc[i] += wc[j];
          live[j] = 1'b0;
        end
      if (wc[i] == '0) live[i] = 1'b0;
    end
    last_idx = -1;
    for (int i = 0; i < wn; i++) if (live[i]) last_idx = i;
    if (last_idx < 0) begin
      b = '{coef: '0, expo: '0, value: '0, empty: 1'b1, dropped: spill_seen, last: 1'b1};
      result_q.push_back(b);
      return;
    end
    for (int i = 0; i < wn; i++)
      if (live[i]) begin
        b = '{coef: wc[i], expo: we[i], value: '0, empty: 1'b0, dropped: spill_seen,
              last: (i == last_idx)};
        result_q.push_back(b);
      end
  endtask

  task automatic absorb_term(input logic sel, input logic [CoefW-1:0] c,
                             input logic [ExpW-1:0] e, input logic lst);
    logic fin_sel;
    if (sel == 1'b0) begin
      if (first_n < MaxTerms) begin
        first_coef[first_n] = c;
        first_exp[first_n]  = e;
        first_n++;
      end else spill_seen = 1'b1;
    end else begin
      if (second_n < MaxTerms) begin
        second_coef[second_n] = c;
        second_exp[second_n]  = e;
        second_n++;
      end else spill_seen = 1'b1;
    end
    fin_sel = !(shadow_cfg.op == OpScale || shadow_cfg.op == OpMono ||
                shadow_cfg.op == OpEval);
    if (!lst || sel != fin_sel) return;
    run_poly();
    first_n    = 0;
    second_n   = 0;
    spill_seen = 1'b0;
  endtask

  // Call at a falling edge; returns at a falling edge with valid still high
  task automatic send_term(input logic sel, input logic [CoefW-1:0] c,
                           input logic [ExpW-1:0] e, input logic lst);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      term_if.valid = 1'b0;
      @(negedge clk_i);
    end
    term_if.valid            = 1'b1;
    term_if.operand_select   = sel;
    term_if.term_coefficient = c;
    term_if.term_exponent    = e;
    term_if.last_term        = lst;
    do @(posedge clk_i); while (!term_if.ready);
    absorb_term(sel, c, e, lst);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [31:0] data);
    term_if.valid = 1'b0;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegOperation: shadow_cfg.op        = data[OpW-1:0];
      RegScale:     shadow_cfg.scale     = data;
      RegPoint:     shadow_cfg.point     = data;
      RegMonoCoef:  shadow_cfg.mono_coef = data;
      RegMonoExp:   shadow_cfg.mono_exp  = data[ExpW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Drain outstanding beats, then give the block time to go idle
  task automatic settle();
    term_if.valid = 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [CoefW-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return CoefMinusOne;
      3:       return '0;
      4, 5:    return 32'($signed($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ExpW-1:0] pick_exp();
    case ($urandom_range(0, 5))
      0:       return 10'd1023;
      1, 2:    return ExpW'($urandom);
      default: return ExpW'($urandom_range(0, 5));
    endcase
  endfunction

  // One well-formed operand sequence for the current operation
  task automatic send_poly(input int max_n);
    logic fin_sel;
    logic [OpW-1:0] op;
    int n_other, n_fin;
    logic [CoefW-1:0] c;
    logic [ExpW-1:0] e;
    op = shadow_cfg.op;
    fin_sel = !(op == OpScale || op == OpMono || op == OpEval);
    n_other = (fin_sel || $urandom_range(0, 5) == 0) ? $urandom_range(0, max_n) : 0;
    n_fin   = $urandom_range(1, max_n);
    for (int i = 0; i < n_other; i++) begin
      c = pick_coef();
      e = pick_exp();
      send_term(!fin_sel, c, e, i == n_other - 1);
    end
    for (int i = 0; i < n_fin; i++) begin
      // sometimes negate the coefficient or reuse the exponent of the first operand's first term
      c = ($urandom_range(0, 3) == 0 && n_other > 0) ? -first_coef[0] : pick_coef();
      e = ($urandom_range(0, 2) == 0 && n_other > 0) ? first_exp[0] : pick_exp();
      send_term(fin_sel, c, e, i == n_fin - 1);
    end
  endtask

  task automatic random_cfg();
    logic [OpW-1:0] op;
    op = OpW'($urandom_range(0, 7));
    write_reg(RegOperation, 32'(op));
    case (op)
      OpScale: write_reg(RegScale, pick_coef());
      OpEval:  write_reg(RegPoint, ($urandom_range(0, 1) == 1) ? pick_coef() :
                                   32'($signed($urandom_range(0, 6)) - 3));
      OpMono: begin
        write_reg(RegMonoCoef, pick_coef());
        write_reg(RegMonoExp, 32'(pick_exp()));
      end
      default: ;
    endcase
  endtask

  task automatic test_directed();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // add with a cancelling pair, last on the first operand ends nothing
    send_term(1'b0, 32'd5, 10'd3, 1'b0);
    send_term(1'b0, -32'd5, 10'd7, 1'b1);
    send_term(1'b1, -32'd5, 10'd3, 1'b0);
    send_term(1'b1, 32'h7FFF_FFFF, 10'd1023, 1'b1);
    // only a zero term loaded gives the empty beat
    send_term(1'b1, 32'd0, 10'd0, 1'b1);
    settle();
    write_reg(RegOperation, 32'(OpSub));
    send_term(1'b0, 32'h8000_0000, 10'd1023, 1'b0);
    send_term(1'b1, 32'h8000_0000, 10'd1023, 1'b1);
    // overfill the first operand
    for (int i = 0; i < MaxTerms + 1; i++)
      send_term(1'b0, 32'(i + 1), 10'(i), 1'b0);
    send_term(1'b1, CoefMinusOne, 10'd0, 1'b1);
    settle();
    write_reg(RegScale, CoefMinusOne);
    write_reg(RegOperation, 32'(OpScale));
    send_term(1'b1, 32'd9, 10'd9, 1'b0);
    send_term(1'b0, 32'h8000_0000, 10'd5, 1'b0);
    send_term(1'b0, 32'd7, 10'd9, 1'b1);
    settle();
    write_reg(RegOperation, 32'(OpProd));
    send_term(1'b0, CoefMinusOne, 10'd1023, 1'b0);
    send_term(1'b0, 32'd2, 10'd0, 1'b1);
    send_term(1'b1, CoefMinusOne, 10'd1023, 1'b1);
    settle();
    write_reg(RegMonoCoef, 32'h8000_0000);
    write_reg(RegMonoExp, 32'd1023);
    write_reg(RegOperation, 32'(OpMono));
    send_term(1'b0, 32'd3, 10'd1023, 1'b1);
    settle();
    write_reg(RegPoint, CoefMinusOne);
    write_reg(RegOperation, 32'(OpEval));
    send_term(1'b0, 32'd1, 10'd1023, 1'b0);
    send_term(1'b0, 32'd5, 10'd0, 1'b1);
    settle();
    write_reg(RegPoint, 32'd0);
    send_term(1'b0, 32'd7, 10'd0, 1'b1);
    settle();
    write_reg(RegPoint, 32'd2);
    send_term(1'b0, 32'd3, 10'd31, 1'b1);
    settle();
    write_reg(RegOperation, 32'(OpSpare7));
    send_term(1'b1, 32'd4, 10'd2, 1'b1);
    settle();
    write_reg(RegOperation, 32'(OpSpare6));
    send_term(1'b0, 32'h7FFF_FFFF, 10'd0, 1'b0);
    send_term(1'b1, 32'h7FFF_FFFF, 10'd0, 1'b1);
    settle();
  endtask

  // Full 8 x 8 product fills the work store
  task automatic test_full_product();
    write_reg(RegOperation, 32'(OpProd));
    for (int i = 0; i < MaxTerms; i++) send_term(1'b0, $urandom, 10'(i * 17), 1'b0);
    for (int j = 0; j < MaxTerms; j++)
      send_term(1'b1, $urandom, 10'(j * 3 + 100), j == MaxTerms - 1);
    settle();
  endtask

  task automatic test_random(input int n_items, input int tx_pct, input int rx_pct);
    int start_cnt;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start_cnt = 0;
    while (start_cnt < n_items) begin
      random_cfg();
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise beat: random operand and last flag
          send_term(1'($urandom_range(0, 1)), pick_coef(), pick_exp(),
                    1'($urandom_range(0, 1)));
          start_cnt++;
        end else begin
          send_poly(($urandom_range(0, 7) == 0) ? MaxTerms + 1 : 3);
          start_cnt += 4;
        end
      end
      // close any open sequence so the next setting starts clean
      send_term(!(shadow_cfg.op == OpScale || shadow_cfg.op == OpMono ||
                  shadow_cfg.op == OpEval), pick_coef(), pick_exp(), 1'b1);
      settle();
    end
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(RegOperation, 32'(OpAdd));
    rx_hold_cycles = 400;
    repeat (6) send_poly(3);
    settle();
  endtask

  // Result sink: ready changes on the falling edge
  always @(negedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles <= rx_hold_cycles - 1;
      res_if.ready   <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    poly_beat_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (result_q.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = result_q.pop_front();
        if (res_if.out_coefficient !== want.coef)
          report($sformatf("coefficient %h, want %h", res_if.out_coefficient, want.coef));
        if (res_if.out_exponent !== want.expo)
          report($sformatf("exponent %0d, want %0d", res_if.out_exponent, want.expo));
        if (res_if.eval_value !== want.value)
          report($sformatf("value %h, want %h", res_if.eval_value, want.value));
        if (res_if.empty_result !== want.empty)
          report($sformatf("empty flag %b, want %b", res_if.empty_result, want.empty));
        if (res_if.terms_dropped !== want.dropped)
          report($sformatf("dropped flag %b, want %b", res_if.terms_dropped, want.dropped));
        if (res_if.last_result !== want.last)
          report($sformatf("last flag %b, want %b", res_if.last_result, want.last));
      end
    end
  end

  // Watchdog: count cycles without any beat moving or register access
  always @(posedge clk_i) begin
    if ((term_if.valid && term_if.ready) || (res_if.valid && res_if.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni                   = 1'b0;
    psel                     = 1'b0;
    penable                  = 1'b0;
    pwrite                   = 1'b0;
    paddr                    = '0;
    pwdata                   = '0;
    term_if.valid            = 1'b0;
    term_if.operand_select   = 1'b0;
    term_if.term_coefficient = '0;
    term_if.term_exponent    = '0;
    term_if.last_term        = 1'b0;
    res_if.ready             = 1'b0;
    rx_hold_cycles           = 0;
    rx_idle_pct              = 0;
    tx_idle_pct              = 0;
    quiet_cycles             = 0;
    err_count                = 0;
    first_n                  = 0;
    second_n                 = 0;
    spill_seen               = 1'b0;
    shadow_cfg = '{op: OpAdd, scale: CoefOne, point: '0, mono_coef: CoefOne, mono_exp: '0};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_full_product();
    test_backpressure();
    test_random(100, 32, 77);
    test_random(100, 77, 32);
    test_random(100, 0, 0);
    settle();
    if (result_q.size() != 0) report("expected beats left over");
    if (err_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/spa_pkg.sv
rtl/core/spa_if.sv
rtl/core/spa_dp.sv
rtl/core/spa_ctrl.sv
rtl/core/sparse_polynomial_alu.sv
tb/tb.sv
